// ----- design/pls_pkg.sv -----
// ============================================================================
// pls_pkg
// Shared types, sizes and codes for the positional list store.
// ============================================================================
package pls_pkg;

    // Capacity of the list and the widths that follow from it.
    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = 4;
    localparam int CMPW  = (CW > PW) ? CW : PW;

    // Command codes.
    localparam logic [2:0] OP_INS_FIRST = 3'd0;
    localparam logic [2:0] OP_INS_LAST  = 3'd1;
    localparam logic [2:0] OP_INS_AT    = 3'd2;
    localparam logic [2:0] OP_DEL_FIRST = 3'd3;
    localparam logic [2:0] OP_DEL_LAST  = 3'd4;
    localparam logic [2:0] OP_DEL_AT    = 3'd5;
    localparam logic [2:0] OP_LIST      = 3'd6;

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic [PW-1:0]      position;
    } cmd_beat_t;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic [PW-1:0]      item_position;
        logic [4:0]         entry_count;
        logic [1:0]         status;
        logic               last;
    } result_beat_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_LIST_RD,
        S_LIST_OUT,
        S_REPLY
    } state_t;

    // Request from the sequencer to the entry memory.
    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [31:0]   wdata;
        logic [AW-1:0] raddr;
    } mem_req_t;

endpackage

// ----- design/positional_list_store.sv -----
// ============================================================================
// positional_list_store
// Bounded ordered list of signed 32-bit values with positional insert,
// delete and list out, kept in a small RAM and walked by a sequencer.
// ============================================================================
//
// Usage. A command beat (opcode, value, position) is taken at a rising edge
// where start is high and busy is low. Busy stays high until the command has
// finished its work; then the next command may be issued at once.
// Every command except list out answers with one result beat that carries
// the entry count after the command and a status. List out answers with one
// beat per stored entry, in order, the final one marked by last, or with a
// single empty beat when nothing is stored.
// Timing. Insert and delete move one entry at a time through the RAM's
// single read and write port, with a read state and then a write state
// for each entry; rejected and unknown commands go straight to the reply.
// List out reads each entry from the RAM and then forms its result beat.
// Each result beat is registered and appears in the cycle after it is
// formed; strobe marks it for exactly one cycle and the receiver cannot
// stall it. Reset empties the list at once; the RAM needs no clearing, as
// only entries below the count are ever read.
//
module positional_list_store
    import pls_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  cmd_beat_t    cmd,
    output logic         busy,
    output logic         strobe,
    output result_beat_t result
);

    mem_req_t    mem_req;
    logic [31:0] mem_rdata;

    // Sequencer with the shared index unit; it owns the count and the
    // result register.
    pls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .strobe    (strobe),
        .result    (result),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // Entry storage: one write and one registered read per cycle.
    pls_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- design/pls_ram.sv -----
// ============================================================================
// pls_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/pls_step.sv -----
// ============================================================================
// pls_step
// Shared index unit: steps the walking index one place up or down and
// compares the new index against the walk's end point.
// ============================================================================
module pls_step
    import pls_pkg::*;
(
    input  logic [AW-1:0] cur,
    input  logic          up,
    input  logic [AW-1:0] limit,
    output logic [AW-1:0] nb,
    output logic          hit
);

    always_comb
    begin
        if (up)
        begin
            nb = cur + AW'(1);
        end
        else
        begin
            nb = cur - AW'(1);
        end
        hit = (nb == limit);
    end

endmodule

// ----- design/pls_ctrl.sv -----
// ============================================================================
// pls_ctrl
// Command sequencer: decodes a command, walks the entry memory one entry
// at a time to shift or list, and registers each result beat.
// ============================================================================
module pls_ctrl
    import pls_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  cmd_beat_t    cmd,
    output logic         busy,
    output logic         strobe,
    output result_beat_t result,
    output mem_req_t     mem_req,
    input  logic [31:0]  mem_rdata
);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   cur_reg, cur_next;
    logic [AW-1:0]   limit_reg, limit_next;
    logic            up_reg, up_next;
    logic [31:0]     value_reg, value_next;
    logic [1:0]      status_reg, status_next;
    result_beat_t    out_reg, out_next;
    logic            strobe_reg, strobe_next;

    logic            accept;
    logic            full;
    logic            empty;
    logic            pos_ok;
    logic [AW-1:0]   pos_idx;
    logic [AW-1:0]   tail_idx;
    logic [AW-1:0]   nb;
    logic            hit;

    pls_step u_step (
        .cur   (cur_reg),
        .up    (up_reg),
        .limit (limit_reg),
        .nb    (nb),
        .hit   (hit)
    );

    assign accept   = start && (state_reg == S_IDLE);
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pos_ok   = (CMPW'(cmd.position) < CMPW'(count_reg));
    assign pos_idx  = AW'(cmd.position);
    assign tail_idx = AW'(count_reg - CW'(1));

    // Datapath register next values.
    always_comb
    begin
        count_next  = count_reg;
        cur_next    = cur_reg;
        limit_next  = limit_reg;
        up_next     = up_reg;
        value_next  = value_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_OK;
                    value_next  = cmd.value;
                    priority if (cmd.opcode == OP_INS_FIRST || cmd.opcode == OP_INS_LAST ||
                                 cmd.opcode == OP_INS_AT)
                    begin
                        // Shifting walks down from the first free slot.
                        up_next  = 1'b0;
                        cur_next = AW'(count_reg);
                        if (full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (cmd.opcode == OP_INS_FIRST)
                        begin
                            limit_next = '0;
                        end
                        else if (cmd.opcode == OP_INS_LAST)
                        begin
                            limit_next = AW'(count_reg);
                        end
                        else if (!pos_ok)
                        begin
                            status_next = STAT_RANGE;
                        end
                        else
                        begin
                            limit_next = pos_idx;
                        end
                    end
                    else if (cmd.opcode == OP_DEL_FIRST || cmd.opcode == OP_DEL_LAST ||
                             cmd.opcode == OP_DEL_AT)
                    begin
                        // Shifting walks up from the removed slot to the tail.
                        up_next    = 1'b1;
                        limit_next = tail_idx;
                        if (empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (cmd.opcode == OP_DEL_FIRST)
                        begin
                            cur_next = '0;
                            if (tail_idx == '0)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        else if (cmd.opcode == OP_DEL_LAST)
                        begin
                            cur_next   = tail_idx;
                            count_next = count_reg - CW'(1);
                        end
                        else if (!pos_ok)
                        begin
                            status_next = STAT_RANGE;
                        end
                        else
                        begin
                            cur_next = pos_idx;
                            if (pos_idx == tail_idx)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                    end
                    else if (cmd.opcode == OP_LIST)
                    begin
                        up_next    = 1'b1;
                        cur_next   = '0;
                        limit_next = tail_idx;
                        if (empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                    end
                    else
                    begin
                        status_next = STAT_OK;
                    end
                end
            end
            S_SHIFT_RD:
            begin
            end
            S_SHIFT_WR:
            begin
                cur_next = nb;
                if (hit && up_reg)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            S_PUT:
            begin
                count_next = count_reg + CW'(1);
            end
            S_LIST_RD:
            begin
            end
            S_LIST_OUT:
            begin
                cur_next = nb;
            end
            S_REPLY:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_REPLY;
                    priority if (cmd.opcode == OP_INS_FIRST || cmd.opcode == OP_INS_LAST ||
                                 cmd.opcode == OP_INS_AT)
                    begin
                        if (!full && (cmd.opcode != OP_INS_AT || pos_ok))
                        begin
                            if (cmd.opcode == OP_INS_LAST ||
                                (cmd.opcode == OP_INS_FIRST && empty) ||
                                (cmd.opcode == OP_INS_AT && pos_idx == AW'(count_reg)))
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                state_next = S_SHIFT_RD;
                            end
                        end
                    end
                    else if (cmd.opcode == OP_DEL_FIRST || cmd.opcode == OP_DEL_AT)
                    begin
                        if (!empty && cmd.opcode == OP_DEL_FIRST && tail_idx != '0)
                        begin
                            state_next = S_SHIFT_RD;
                        end
                        else if (!empty && cmd.opcode == OP_DEL_AT && pos_ok &&
                                 pos_idx != tail_idx)
                        begin
                            state_next = S_SHIFT_RD;
                        end
                    end
                    else if (cmd.opcode == OP_LIST)
                    begin
                        if (!empty)
                        begin
                            state_next = S_LIST_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_REPLY;
                    end
                end
            end
            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                if (!hit)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (up_reg)
                begin
                    state_next = S_REPLY;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                state_next = S_REPLY;
            end
            S_LIST_RD:
            begin
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (cur_reg == limit_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_LIST_RD;
                end
            end
            S_REPLY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory requests and result beats.
    always_comb
    begin
        mem_req.we    = 1'b0;
        mem_req.waddr = cur_reg;
        mem_req.wdata = mem_rdata;
        mem_req.raddr = cur_reg;
        out_next      = out_reg;
        strobe_next   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_SHIFT_RD:
            begin
                mem_req.raddr = nb;
            end
            S_SHIFT_WR:
            begin
                mem_req.we = 1'b1;
            end
            S_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = limit_reg;
                mem_req.wdata = value_reg;
            end
            S_LIST_RD:
            begin
            end
            S_LIST_OUT:
            begin
                strobe_next            = 1'b1;
                out_next.item_value    = mem_rdata;
                out_next.item_position = PW'(cur_reg);
                out_next.entry_count   = 5'(count_reg);
                out_next.status        = STAT_OK;
                out_next.last          = (cur_reg == limit_reg);
            end
            S_REPLY:
            begin
                strobe_next            = 1'b1;
                out_next.item_value    = '0;
                out_next.item_position = '0;
                out_next.entry_count   = 5'(count_reg);
                out_next.status        = status_reg;
                out_next.last          = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        limit_reg  <= limit_next;
        up_reg     <= up_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = out_reg;

endmodule

// ----- design/pls_chk.sv -----
// ============================================================================
// pls_chk
// Port level checks for the positional list store, bound to the top level.
// ============================================================================
module pls_chk
    import pls_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input logic         strobe,
    input result_beat_t result
);

    // An accepted command always raises busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted command");

    // More beats are still owed while a non-final beat is shown.
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("block idle with list beats outstanding");

    // A non-final list beat is followed by the next list beat, with strobe low between them.
    a_list_pace: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> !strobe ##1 strobe)
        else $error("list beat spacing broken");

    // A failing status is a single beat with no entry data.
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status != STAT_OK |-> result.last && result.item_value == '0)
        else $error("error status beat malformed");

    // The count never exceeds the capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> result.entry_count <= 5'(DEPTH))
        else $error("entry count above capacity");

endmodule

bind positional_list_store pls_chk u_pls_chk (.*);

// ----- tb/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for the positional list store. Commands are driven on
// the falling edge and accepted on start and not busy. An in-bench shadow of
// the list predicts every result beat, and each strobed beat is checked field
// by field against the oldest prediction. A directed pass covers the empty,
// full and out-of-range cases. Random traffic in grow, shrink and balanced
// phases follows it, with bursty issue and idle gaps.
// ============================================================================
module tb;
    import pls_pkg::*;

    // Opcode 7 has no meaning in the block and must answer with a plain status.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    localparam int RANDOM_ITEMS   = 400;
    localparam int DRAIN_TAIL     = 40;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} traffic_mix_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    cmd_beat_t    cmd = '0;
    logic         busy;
    logic         strobe;
    result_beat_t result;

    // Shadow copy of the list contents and the beats still owed by the block.
    logic signed [31:0] shadow_entries [DEPTH];
    int                 shadow_count = 0;
    result_beat_t       expected_beats [$];

    int mismatch_count = 0;
    int beat_index     = 0;
    int quiet_cycles   = 0;

    positional_list_store i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("tb: %s", msg);
        end
    endtask

    // Applies one accepted command to the shadow list and queues the beats
    // that it must produce.
    task automatic predict_list_op(input cmd_beat_t c);
        result_beat_t beat;
        logic [1:0]   stat;
        int           slot;
        int           i;
        stat = STAT_OK;
        slot = -1;
        beat = '0;
        case (c.opcode)
            OP_INS_FIRST, OP_INS_LAST, OP_INS_AT:
            begin
                // Fullness wins over a bad index.
                if (shadow_count >= DEPTH)
                    stat = STAT_FULL;
                else if (c.opcode == OP_INS_FIRST)
                    slot = 0;
                else if (c.opcode == OP_INS_LAST)
                    slot = shadow_count;
                else if (int'(c.position) >= shadow_count)
                    stat = STAT_RANGE;
                else
                    slot = int'(c.position);
                if (slot >= 0)
                begin
                    for (i = shadow_count; i > slot; i--)
                        shadow_entries[AW'(i)] = shadow_entries[AW'(i - 1)];
                    shadow_entries[AW'(slot)] = c.value;
                    shadow_count++;
                end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT:
            begin
                // Emptiness wins over a bad index.
                if (shadow_count == 0)
                    stat = STAT_EMPTY;
                else if (c.opcode == OP_DEL_FIRST)
                    slot = 0;
                else if (c.opcode == OP_DEL_LAST)
                    slot = shadow_count - 1;
                else if (int'(c.position) >= shadow_count)
                    stat = STAT_RANGE;
                else
                    slot = int'(c.position);
                if (slot >= 0)
                begin
                    for (i = slot; i + 1 < shadow_count; i++)
                        shadow_entries[AW'(i)] = shadow_entries[AW'(i + 1)];
                    shadow_count--;
                end
            end
            OP_LIST:
            begin
                if (shadow_count > 0)
                begin
                    for (i = 0; i < shadow_count; i++)
                    begin
                        beat.item_value    = shadow_entries[AW'(i)];
                        beat.item_position = i[PW-1:0];
                        beat.entry_count   = shadow_count[4:0];
                        beat.status        = STAT_OK;
                        beat.last          = (i == shadow_count - 1);
                        expected_beats.push_back(beat);
                    end
                    return;
                end
                stat = STAT_EMPTY;
            end
            default:
            begin
                stat = STAT_OK;
            end
        endcase
        beat.item_value    = '0;
        beat.item_position = '0;
        beat.entry_count   = shadow_count[4:0];
        beat.status        = stat;
        beat.last          = 1'b1;
        expected_beats.push_back(beat);
    endtask

    task automatic check_result(input result_beat_t got);
        result_beat_t want;
        if (expected_beats.size() == 0)
        begin
            note_failure($sformatf(
                "result %0d unexpected: value %0d pos %0d count %0d status %0d last %0d",
                beat_index, got.item_value, got.item_position, got.entry_count,
                got.status, got.last));
        end
        else
        begin
            want = expected_beats.pop_front();
            if (got.item_value !== want.item_value
                || got.item_position !== want.item_position
                || got.entry_count !== want.entry_count
                || got.status !== want.status
                || got.last !== want.last)
            begin
                note_failure($sformatf({"result %0d mismatch: expected value %0d pos %0d ",
                    "count %0d status %0d last %0d, got value %0d pos %0d count %0d ",
                    "status %0d last %0d"},
                    beat_index, want.item_value, want.item_position, want.entry_count,
                    want.status, want.last, got.item_value, got.item_position,
                    got.entry_count, got.status, got.last));
            end
        end
        beat_index++;
    endtask

    // Result beats are checked before the command taken at the same edge is
    // predicted, so a beat can never be matched against its own command.
    // The watchdog ends the run after a long stretch with no beat moving.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
                check_result(result);
            if (start && !busy)
                predict_list_op(cmd);
            if (strobe || (start && !busy))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("tb: done, errors");
                    $finish;
                end
            end
        end
    end

    function automatic cmd_beat_t cmd_of(input logic [2:0] op,
                                         input logic [31:0] val,
                                         input logic [3:0] pos);
        cmd_beat_t c;
        c.opcode   = op;
        c.value    = val;
        c.position = pos;
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat
    // was taken, with start still high so a following beat can go at once.
    task automatic issue(input cmd_beat_t c);
        start = 1'b1;
        cmd   = c;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Drops start for a number of cycles and shows junk on the command bus.
    task automatic idle_gap(input int cycles);
        start = 1'b0;
        cmd   = cmd_of(3'($urandom_range(0, 7)), $urandom, 4'($urandom_range(0, 15)));
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        idle_gap(1);
        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    function automatic cmd_beat_t random_cmd(input traffic_mix_t mix);
        int         roll;
        int         grow_pct;
        logic [2:0] op;
        logic [31:0] val;
        logic [3:0] pos;
        grow_pct = (mix == MIX_GROW) ? 75 : (mix == MIX_SHRINK) ? 25 : 50;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            op = OP_LIST;
        else if (roll < 10)
            op = OP_UNUSED;
        else if ($urandom_range(0, 99) < grow_pct)
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_INS_FIRST;
                1:       op = OP_INS_LAST;
                default: op = OP_INS_AT;
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_DEL_FIRST;
                1:       op = OP_DEL_LAST;
                default: op = OP_DEL_AT;
            endcase
        end
        // Mostly a valid index, sometimes anything the field can hold.
        if (shadow_count > 0 && $urandom_range(0, 3) != 0)
            pos = 4'($urandom_range(0, shadow_count - 1));
        else
            pos = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 15))
            0:       val = VAL_MAX;
            1:       val = VAL_MIN;
            2:       val = '0;
            3:       val = '1;
            default: val = $urandom;
        endcase
        return cmd_of(op, val, pos);
    endfunction

    // Every rejection on an empty list, then the three inserts and three
    // deletes at both ends and in the middle, with the value extremes.
    task automatic test_directed_edges();
        issue(cmd_of(OP_LIST, 0, 0));
        issue(cmd_of(OP_DEL_FIRST, 0, 0));
        issue(cmd_of(OP_DEL_LAST, 0, 0));
        issue(cmd_of(OP_DEL_AT, 0, 0));
        issue(cmd_of(OP_INS_AT, 32'h1234_5678, 0));
        issue(cmd_of(OP_INS_FIRST, VAL_MAX, 0));
        issue(cmd_of(OP_INS_LAST, VAL_MIN, 0));
        issue(cmd_of(OP_INS_AT, 0, 0));
        issue(cmd_of(OP_INS_AT, '1, 2));
        issue(cmd_of(OP_INS_AT, 32'h5A5A_A5A5, 4));
        issue(cmd_of(OP_INS_AT, 32'hA5A5_5A5A, 15));
        issue(cmd_of(OP_UNUSED, '1, 15));
        issue(cmd_of(OP_LIST, 0, 0));
        issue(cmd_of(OP_DEL_AT, 0, 15));
        issue(cmd_of(OP_DEL_AT, 0, 4));
        issue(cmd_of(OP_DEL_AT, 0, 1));
        issue(cmd_of(OP_DEL_FIRST, 0, 0));
        issue(cmd_of(OP_DEL_LAST, 0, 0));
        issue(cmd_of(OP_LIST, 0, 0));
        issue(cmd_of(OP_DEL_AT, 0, 0));
        issue(cmd_of(OP_LIST, 0, 0));
        wait_drained();
    endtask

    // Fills the list, checks that every kind of insert is refused when full,
    // lists all entries, and drains it back to empty.
    task automatic test_full_store();
        int k;
        for (k = 0; k < DEPTH; k++)
        begin
            issue(cmd_of((k % 2) ? OP_INS_LAST : OP_INS_FIRST, $urandom, 0));
            if ($urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 4));
        end
        issue(cmd_of(OP_INS_FIRST, $urandom, 0));
        issue(cmd_of(OP_INS_LAST, $urandom, 0));
        issue(cmd_of(OP_INS_AT, $urandom, 15));
        issue(cmd_of(OP_INS_AT, $urandom, 0));
        issue(cmd_of(OP_LIST, 0, 0));
        issue(cmd_of(OP_DEL_AT, 0, 15));
        issue(cmd_of(OP_INS_AT, $urandom, 14));
        issue(cmd_of(OP_LIST, 0, 0));
        while (shadow_count > 0)
        begin
            case ($urandom_range(0, 2))
                0:       issue(cmd_of(OP_DEL_FIRST, $urandom, 0));
                1:       issue(cmd_of(OP_DEL_LAST, $urandom, 0));
                default: issue(cmd_of(OP_DEL_AT, $urandom,
                                      4'($urandom_range(0, shadow_count - 1))));
            endcase
        end
        issue(cmd_of(OP_LIST, 0, 0));
        wait_drained();
    endtask

    // Phases that grow, shrink or churn the list, issued in bursts with
    // random gaps. The first phase boundary always waits for every owed beat.
    task automatic test_random_traffic();
        int           sent;
        int           burst;
        int           phase_left;
        bit           drained_once;
        traffic_mix_t mix;
        sent = 0;
        drained_once = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            mix = traffic_mix_t'($urandom_range(0, 2));
            phase_left = $urandom_range(10, 40);
            while (phase_left > 0 && sent < RANDOM_ITEMS)
            begin
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 12);
                while (burst > 0 && phase_left > 0 && sent < RANDOM_ITEMS)
                begin
                    issue(random_cmd(mix));
                    burst--;
                    phase_left--;
                    sent++;
                end
                idle_gap($urandom_range(1, 10));
            end
            if (!drained_once || $urandom_range(0, 3) == 0)
            begin
                wait_drained();
                drained_once = 1'b1;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_full_store();
        test_random_traffic();
        wait_drained();

        if (expected_beats.size() != 0)
            note_failure($sformatf("%0d result beats never arrived",
                                   expected_beats.size()));
        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- positional_list_store.f -----
design/pls_pkg.sv
design/pls_ram.sv
design/pls_step.sv
design/pls_ctrl.sv
design/positional_list_store.sv
design/pls_chk.sv
tb/tb.sv
